### src/lrupfr_pkg.sv
`timescale 1ns / 1ps

package lrupfr_pkg;

  // Frame store geometry
  localparam int FRAMES  = 4;
  localparam int FRAME_W = $clog2(FRAMES);
  localparam int CNT_W   = $clog2(FRAMES + 1);

  // Field widths
  localparam int PAGE_W   = 10;
  localparam int VADDR_W  = 14;
  localparam int AGE_W    = 16;
  localparam int FAULT_W  = 16;
  localparam int FIDX_W   = 2;
  localparam int OFFSET_W = 4;
  localparam int ENTRY_W  = PAGE_W + AGE_W;

  // Divide by ten: q = (v * 52429) >> 19, exact for v below 43690
  localparam int DIV10_RECIP = 52429;
  localparam int DIV10_SHIFT = 19;
  localparam int PROD_W      = VADDR_W + 16;
  localparam int QUO_W       = PROD_W - DIV10_SHIFT;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN,
    ST_HOLD
  } lrupfr_state_t;

  // Saturating age step
  function automatic logic [AGE_W-1:0] age_step(input logic [AGE_W-1:0] age);
    age_step = (age == {AGE_W{1'b1}}) ? age : age + AGE_W'(1);
  endfunction

endpackage

### src/lru_page_frame_replacer.sv
`timescale 1ns / 1ps

// Channel  | Ports                                         | Flow
// ---------+-----------------------------------------------+-------------------
// in       | in_valid, in_stall, in_page_number,           | access beat in
//          | in_virtual_address                            |
// out      | out_valid, out_stall, out_hit, out_frame_index,| result beat out
//          | out_page_offset, out_fault_total              |
//
// Each beat walks the frames with one read per frame from the frame memory,
// waits for the last read to return, and then commits by writing the chosen
// frame. Ages are written back, incremented, during the walk itself. Reset
// (rst_n low, synchronous) empties all frames and clears the fault count; no
// memory sweep is needed. A stalled result is held in the output register;
// the next beat is taken only after the result has been loaded there.
module lru_page_frame_replacer (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [lrupfr_pkg::PAGE_W-1:0]       in_page_number,
  input  logic [lrupfr_pkg::VADDR_W-1:0]      in_virtual_address,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_hit,
  output logic [lrupfr_pkg::FIDX_W-1:0]       out_frame_index,
  output logic [lrupfr_pkg::OFFSET_W-1:0]     out_page_offset,
  output logic [lrupfr_pkg::FAULT_W-1:0]      out_fault_total
);
  import lrupfr_pkg::*;

  localparam logic [FRAME_W-1:0] LAST_FRAME = FRAME_W'(FRAMES - 1);

  // Frame memory: {page, age} per frame
  logic [ENTRY_W-1:0] frame_mem [FRAMES];

  lrupfr_state_t       state_r, state_nxt;
  logic [FRAMES-1:0]   frame_valid_r, frame_valid_nxt;
  logic [FAULT_W-1:0]  fault_cnt_r, fault_cnt_nxt;

  logic [PAGE_W-1:0]   page_r;
  logic [VADDR_W-1:0]  vaddr_r;
  logic [QUO_W-1:0]    quo_r;

  logic [CNT_W-1:0]    iss_r, iss_nxt;
  logic                rd_vld_r;
  logic [FRAME_W-1:0]  rd_idx_r;
  logic [ENTRY_W-1:0]  rd_data_r;

  logic                found_r, found_nxt;
  logic                hit_r, hit_nxt;
  logic [FRAME_W-1:0]  fsel_r, fsel_nxt;
  logic [AGE_W-1:0]    best_age_r, best_age_nxt;
  logic [FRAME_W-1:0]  best_idx_r, best_idx_nxt;

  logic                out_valid_r;
  logic                out_hit_r;
  logic [FIDX_W-1:0]   out_fidx_r;
  logic [OFFSET_W-1:0] out_off_r;
  logic [FAULT_W-1:0]  out_fault_r;

  logic                in_acc;
  logic                rd_en;
  logic [FRAME_W-1:0]  rd_addr;
  logic                wr_en;
  logic [FRAME_W-1:0]  wr_addr;
  logic [ENTRY_W-1:0]  wr_data;
  logic                out_ld;
  logic [PAGE_W-1:0]   rd_page;
  logic [AGE_W-1:0]    rd_age;
  logic [FRAME_W-1:0]  sel;
  logic                res_hit;
  logic [FAULT_W-1:0]  fault_upd;
  logic [FAULT_W-1:0]  res_fault;
  logic [PROD_W-1:0]   prod;
  logic [VADDR_W-1:0]  ten_q;
  logic [VADDR_W-1:0]  rem;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign rd_page  = rd_data_r[ENTRY_W-1:AGE_W];
  assign rd_age   = rd_data_r[AGE_W-1:0];

  // Chosen frame: first empty or matching frame, else the oldest
  assign sel       = found_r ? fsel_r : best_idx_r;
  assign res_hit   = found_r && hit_r;
  assign fault_upd = (res_hit || fault_cnt_r == {FAULT_W{1'b1}}) ?
                     fault_cnt_r : fault_cnt_r + FAULT_W'(1);
  assign res_fault = (state_r == ST_FIN) ? fault_upd : fault_cnt_r;

  // Offset: address mod ten by reciprocal multiply
  assign prod  = PROD_W'(vaddr_r) * PROD_W'(DIV10_RECIP);
  assign ten_q = VADDR_W'({quo_r, 3'b000}) + VADDR_W'({quo_r, 1'b0});
  assign rem   = vaddr_r - ten_q;

  assign out_ld = (state_r == ST_FIN || state_r == ST_HOLD) &&
                  (!out_valid_r || !out_stall);

  // Sequencer, walk and commit
  always_comb begin
    state_nxt       = state_r;
    frame_valid_nxt = frame_valid_r;
    fault_cnt_nxt   = fault_cnt_r;
    iss_nxt         = iss_r;
    found_nxt       = found_r;
    hit_nxt         = hit_r;
    fsel_nxt        = fsel_r;
    best_age_nxt    = best_age_r;
    best_idx_nxt    = best_idx_r;
    rd_en           = 1'b0;
    rd_addr         = iss_r[FRAME_W-1:0];
    wr_en           = 1'b0;
    wr_addr         = rd_idx_r;
    wr_data         = {rd_page, age_step(rd_age)};

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_SCAN;
          iss_nxt   = '0;
          found_nxt = 1'b0;
          hit_nxt   = 1'b0;
        end
      end
      ST_SCAN: begin
        // issue one frame read per cycle
        if (iss_r < CNT_W'(FRAMES)) begin
          rd_en   = 1'b1;
          iss_nxt = iss_r + CNT_W'(1);
        end
        // examine returned frame, write its age back incremented
        if (rd_vld_r) begin
          wr_en = 1'b1;
          if (!found_r) begin
            if (!frame_valid_r[rd_idx_r]) begin
              found_nxt = 1'b1;
              fsel_nxt  = rd_idx_r;
            end else if (rd_page == page_r) begin
              found_nxt = 1'b1;
              hit_nxt   = 1'b1;
              fsel_nxt  = rd_idx_r;
            end
          end
          if (rd_idx_r == '0 || rd_age > best_age_r) begin
            best_age_nxt = rd_age;
            best_idx_nxt = rd_idx_r;
          end
          if (rd_idx_r == LAST_FRAME) begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        wr_en                = 1'b1;
        wr_addr              = sel;
        wr_data              = {page_r, {AGE_W{1'b0}}};
        frame_valid_nxt[sel] = 1'b1;
        fault_cnt_nxt        = fault_upd;
        state_nxt            = out_ld ? ST_IDLE : ST_HOLD;
      end
      ST_HOLD: begin
        if (out_ld) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      frame_valid_r <= '0;
      fault_cnt_r   <= '0;
      rd_vld_r      <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      frame_valid_r <= frame_valid_nxt;
      fault_cnt_r   <= fault_cnt_nxt;
      rd_vld_r      <= rd_en;
      if (out_ld) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Walk registers and captured beat
  always_ff @(posedge clk) begin
    iss_r      <= iss_nxt;
    found_r    <= found_nxt;
    hit_r      <= hit_nxt;
    fsel_r     <= fsel_nxt;
    best_age_r <= best_age_nxt;
    best_idx_r <= best_idx_nxt;
    rd_idx_r   <= rd_addr;
    quo_r      <= prod[PROD_W-1:DIV10_SHIFT];
    if (in_acc) begin
      page_r  <= in_page_number;
      vaddr_r <= in_virtual_address;
    end
  end

  // Frame memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      frame_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= frame_mem[rd_addr];
  end

  // Output register
  always_ff @(posedge clk) begin
    if (out_ld) begin
      out_hit_r   <= res_hit;
      out_fidx_r  <= FIDX_W'(sel);
      out_off_r   <= rem[OFFSET_W-1:0];
      out_fault_r <= res_fault;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_frame_index = out_fidx_r;
  assign out_page_offset = out_off_r;
  assign out_fault_total = out_fault_r;

  // Frames fill in order: occupied frames form a prefix
  a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    ((frame_valid_r >> 1) & ~frame_valid_r) == '0)
    else $error("occupied frames not a prefix");

  // The committed frame is occupied afterwards
  a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FIN |=> frame_valid_r[$past(sel)])
    else $error("committed frame not marked occupied");

  // Fault count never goes down outside reset
  a_fault_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> fault_cnt_r >= $past(fault_cnt_r))
    else $error("fault count decreased");

  // Commit only follows a completed walk
  a_fin_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && state_r == ST_FIN |-> $past(state_r) == ST_SCAN)
    else $error("commit without walk");

endmodule

### test/lrupfr_checker.sv
`timescale 1ns / 1ps

module lrupfr_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [lrupfr_pkg::PAGE_W-1:0]   in_page_number,
  input  logic [lrupfr_pkg::VADDR_W-1:0]  in_virtual_address,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic                            out_hit,
  input  logic [lrupfr_pkg::FIDX_W-1:0]   out_frame_index,
  input  logic [lrupfr_pkg::OFFSET_W-1:0] out_page_offset,
  input  logic [lrupfr_pkg::FAULT_W-1:0]  out_fault_total,
  output int                              fail_count,
  output int                              pending,
  output int                              result_count,
  output int                              hit_count
);
  import lrupfr_pkg::*;

  typedef struct packed {
    logic                hit;
    logic [FIDX_W-1:0]   frame;
    logic [OFFSET_W-1:0] offset;
    logic [FAULT_W-1:0]  faults;
  } access_result_t;

  // Shadow copy of the frame table
  logic [PAGE_W-1:0]  held_page  [FRAMES];
  logic               frame_used [FRAMES];
  logic [AGE_W-1:0]   frame_age  [FRAMES];
  logic [FAULT_W-1:0] fault_tally;

  // Access results still owed by the block, oldest first
  access_result_t     owed_results [$];

  // One LRU lookup: first empty or matching frame, else the oldest one
  task automatic lru_access(input logic [PAGE_W-1:0] page,
                            input logic [VADDR_W-1:0] vaddr,
                            output access_result_t res);
    int               sel;
    bit               found;
    bit               is_hit;
    logic [AGE_W-1:0] oldest;
    sel    = 0;
    found  = 1'b0;
    is_hit = 1'b0;
    for (int k = 0; k < FRAMES; k++) begin
      if (!found) begin
        if (!frame_used[k]) begin
          sel   = k;
          found = 1'b1;
        end else if (held_page[k] == page) begin
          sel    = k;
          found  = 1'b1;
          is_hit = 1'b1;
        end
      end
    end
    // all frames full: strictly greater age wins, so ties keep the lower frame
    if (!found) begin
      oldest = frame_age[0];
      sel    = 0;
      for (int k = 1; k < FRAMES; k++) begin
        if (frame_age[k] > oldest) begin
          oldest = frame_age[k];
          sel    = k;
        end
      end
    end
    if (!is_hit) begin
      held_page[sel]  = page;
      frame_used[sel] = 1'b1;
      if (fault_tally != {FAULT_W{1'b1}}) fault_tally = fault_tally + 1'b1;
    end
    // saturating age step, then the touched frame restarts
    for (int k = 0; k < FRAMES; k++) begin
      if (frame_age[k] != {AGE_W{1'b1}}) frame_age[k] = frame_age[k] + 1'b1;
    end
    frame_age[sel] = '0;
    res.hit    = is_hit;
    res.frame  = FIDX_W'(sel);
    res.offset = OFFSET_W'(32'(vaddr) % 10);
    res.faults = fault_tally;
  endtask

  // Watch both channels at the rising edge
  always @(posedge clk) begin : watch
    access_result_t want;
    access_result_t got;
    if (!rst_n) begin
      for (int k = 0; k < FRAMES; k++) begin
        held_page[k]  = '0;
        frame_used[k] = 1'b0;
        frame_age[k]  = '0;
      end
      fault_tally = '0;
      owed_results.delete();
      fail_count   = 0;
      result_count = 0;
      hit_count    = 0;
    end else begin
      // result beat first: it can only belong to an earlier access
      if (out_valid && !out_stall) begin
        got = '{out_hit, out_frame_index, out_page_offset, out_fault_total};
        result_count++;
        if (out_hit) hit_count++;
        if (owed_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected result beat hit=%0d frame=%0d offset=%0d faults=%0d",
                     $realtime, got.hit, got.frame, got.offset, got.faults);
        end else begin
          want = owed_results.pop_front();
          if (got.hit !== want.hit || got.frame !== want.frame ||
              got.offset !== want.offset || got.faults !== want.faults) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: exp hit=%0d frame=%0d off=%0d faults=%0d, got %0d %0d %0d %0d",
                       $realtime, want.hit, want.frame, want.offset, want.faults,
                       got.hit, got.frame, got.offset, got.faults);
          end
        end
      end
      if (in_valid && !in_stall) begin
        lru_access(in_page_number, in_virtual_address, want);
        owed_results.push_back(want);
      end
    end
    pending = owed_results.size();
  end

endmodule

### test/lru_page_frame_replacer_tb.sv
`timescale 1ns / 1ps

module lru_page_frame_replacer_tb;
  import lrupfr_pkg::*;

  localparam int RAND_ITEMS     = 1300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int DIR_ITEMS      = 20;

  // Directed accesses: fill in order, hit before an empty frame, evictions,
  // field extremes and every offset
  localparam int DIR_PAGE [DIR_ITEMS] = '{
    0, 1023, 0, 512, 341, 682, 1023, 0, 7, 7,
    512, 341, 682, 1, 2, 3, 4, 1, 1023, 0
  };
  localparam int DIR_VADDR [DIR_ITEMS] = '{
    0, 10239, 9, 8192, 6143, 2048, 4095, 1, 12, 23,
    34, 45, 56, 67, 78, 89, 90, 10230, 5555, 10239
  };

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [PAGE_W-1:0]   in_page_number = '0;
  logic [VADDR_W-1:0]  in_virtual_address = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                out_hit;
  logic [FIDX_W-1:0]   out_frame_index;
  logic [OFFSET_W-1:0] out_page_offset;
  logic [FAULT_W-1:0]  out_fault_total;

  int fail_count;
  int pending;
  int result_count;
  int hit_count;

  bit in_fire = 1'b0;
  bit out_fire = 1'b0;
  bit tx_quiet = 1'b0;
  bit rx_quiet = 1'b0;
  bit rx_drawn = 1'b0;
  int rx_hold = 0;
  int idle_cycles = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  lru_page_frame_replacer u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_page_number     (in_page_number),
    .in_virtual_address (in_virtual_address),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_hit            (out_hit),
    .out_frame_index    (out_frame_index),
    .out_page_offset    (out_page_offset),
    .out_fault_total    (out_fault_total)
  );

  lrupfr_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_page_number     (in_page_number),
    .in_virtual_address (in_virtual_address),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_hit            (out_hit),
    .out_frame_index    (out_frame_index),
    .out_page_offset    (out_page_offset),
    .out_fault_total    (out_fault_total),
    .fail_count         (fail_count),
    .pending            (pending),
    .result_count       (result_count),
    .hit_count          (hit_count)
  );

  // Beats taken at each rising edge, read back at the falling edge
  always @(posedge clk) begin
    in_fire  <= in_valid && !in_stall;
    out_fire <= out_valid && !out_stall;
  end

  // Result side: out_stall holds off each new result for a random rx_hold, zero in quiet spells
  always @(negedge clk) begin
    if (out_fire) rx_drawn = 1'b0;
    if (out_valid && !rx_drawn) begin
      rx_drawn = 1'b1;
      if ($urandom_range(0, 39) == 0) rx_quiet = !rx_quiet;
      rx_hold = rx_quiet ? 0 : $urandom_range(0, 5);
    end
    if (rx_hold > 0) begin
      out_stall <= 1'b1;
      rx_hold--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog on cycles with no beat on either channel
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_fire || out_fire) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout: no beat for %0d cycles, %0d results owed", idle_cycles, pending);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  function automatic int tx_gap();
    return tx_quiet ? 0 : $urandom_range(0, 5);
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat
  task automatic send_access(input logic [PAGE_W-1:0] page,
                             input logic [VADDR_W-1:0] vaddr,
                             input int gap);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid           <= 1'b1;
    in_page_number     <= page;
    in_virtual_address <= vaddr;
    do @(negedge clk); while (!in_fire);
  endtask

  initial begin
    int                 ws_page [8];
    int                 ws_size;
    logic [PAGE_W-1:0]  page;
    logic [VADDR_W-1:0] vaddr;

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part
    for (int i = 0; i < DIR_ITEMS; i++)
      send_access(PAGE_W'(DIR_PAGE[i]), VADDR_W'(DIR_VADDR[i]), tx_gap());

    // Random part: mostly a small working set, so hits and LRU evictions mix
    ws_size = 2;
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i % 50 == 0) begin
        ws_size  = $urandom_range(2, 7);
        tx_quiet = ($urandom_range(0, 3) == 0);
        for (int j = 0; j < ws_size; j++)
          ws_page[j] = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 1023 : 0)
                                                   : $urandom_range(0, 1023);
      end
      if ($urandom_range(0, 9) < 7) page = PAGE_W'(ws_page[$urandom_range(0, ws_size - 1)]);
      else page = PAGE_W'($urandom_range(0, 1023));
      if ($urandom_range(0, 15) == 0) vaddr = VADDR_W'($urandom_range(0, 1) ? 10239 : 0);
      else vaddr = VADDR_W'($urandom_range(0, 10239));
      send_access(page, vaddr, tx_gap());
    end

    // A few fully random accesses with gaps on both sides
    tx_quiet = 1'b0;
    for (int i = 0; i < 8; i++)
      send_access(PAGE_W'($urandom_range(0, 1023)), VADDR_W'($urandom_range(0, 10239)),
                  tx_gap());
    in_valid <= 1'b0;

    // Drain
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Checked %0d accesses: %0d hits, %0d faults, %0d failures.",
             result_count, hit_count, result_count - hit_count, fail_count);
    $display("Runs: directed fills and evictions, working-set random with idle gaps.");
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
